// ===== sv/lfu_pkg.sv =====
// shared types and constants for the lfu cache table
package lfu_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CFG_W = 5;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
	localparam logic [31:0] USES_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	typedef struct packed {
		logic kind;
		logic signed [31:0] lookup_key;
		logic signed [31:0] store_value;
	} req_t;

	typedef struct packed {
		logic found;
		logic signed [31:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] data;
		logic [31:0] uses;
	} entry_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_FIND,
		OP_BUMP,
		OP_EVICT,
		OP_INSERT,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic put;
		logic cap_zero;
		logic full;
	} stat_t;

endpackage

// ===== sv/lfu_cache_table_core.sv =====
// top level of the lfu cache table: key-value cache with lfu replacement
//
// request channel req/req_valid/req_ready carries one word: a get or a put
// with its key and value. response channel rsp/rsp_valid/rsp_ready returns
// exactly one word per request: found flag and the read value (value on a
// get hit, all ones on a get miss, zero for a put).
// cfg_we/cfg_data writes the capacity register; write it only while idle.
// a request passes through the find, apply and result steps; when a put of
// a new key meets a full cache, the apply step first evicts entries until
// there is room. the chain reorder is one register update per step, so one
// request is in flight at a time and a new request is taken only in idle.
// the response sits in an output register; the next request is accepted
// while it waits, and only the result step stalls until it is taken.
// reset empties the cache and sets the capacity to 16; no clearing pass.
module lfu_cache_table_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  lfu_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output lfu_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [lfu_pkg::CFG_W-1:0] cfg_data
);

	lfu_pkg::cmd_t cmd;
	lfu_pkg::stat_t stat;
	logic [lfu_pkg::CNT_W-1:0] occupancy;

	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lfu_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.occupancy (occupancy)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= lfu_pkg::CNT_W'(lfu_pkg::CAPACITY))
		else $error("occupancy above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response raised too soon");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == lfu_pkg::OP_INSERT |=> occupancy == $past(occupancy) + lfu_pkg::CNT_W'(1))
		else $error("insert did not grow occupancy");

endmodule

// ===== sv/lfu_datapath.sv =====
// entry chain, key match, reorder and result register of the lfu cache table
module lfu_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfu_pkg::cmd_t               cmd,
	output lfu_pkg::stat_t              stat,
	input  lfu_pkg::req_t               req,
	output lfu_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CFG_W-1:0]   cfg_data,
	output logic [lfu_pkg::CNT_W-1:0]   occupancy
);

	lfu_pkg::entry_t ent_q [lfu_pkg::CAPACITY];
	lfu_pkg::entry_t bump_d [lfu_pkg::CAPACITY];
	lfu_pkg::entry_t evict_d [lfu_pkg::CAPACITY];
	lfu_pkg::entry_t ins_d [lfu_pkg::CAPACITY];
	logic [lfu_pkg::CNT_W-1:0] occ_q;
	logic [lfu_pkg::CFG_W-1:0] cap_q;
	logic [31:0] key_q;
	logic [31:0] val_q;
	logic put_q;
	logic found_q;
	logic [lfu_pkg::IDX_W-1:0] slot_q;
	logic [31:0] hit_data_q;
	lfu_pkg::rsp_t rsp_q;

	logic match_any;
	logic [lfu_pkg::IDX_W-1:0] match_idx;
	logic [31:0] uses_new;
	logic [lfu_pkg::CNT_W-1:0] q_pos;
	logic [lfu_pkg::CNT_W-1:0] z_pos;
	lfu_pkg::entry_t moved;
	lfu_pkg::entry_t fresh;
	logic [lfu_pkg::CMP_W-1:0] eff_cap;
	logic cap_zero;

	always_comb begin
		if (lfu_pkg::CMP_W'(cap_q) > lfu_pkg::CMP_W'(lfu_pkg::CAPACITY))
			eff_cap = lfu_pkg::CMP_W'(lfu_pkg::CAPACITY);
		else
			eff_cap = lfu_pkg::CMP_W'(cap_q);
	end

	assign cap_zero = (eff_cap == '0);

	// first occupied slot holding the key
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int i = lfu_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (lfu_pkg::CNT_W'(i) < occ_q && ent_q[i].key == key_q) begin
				match_any = 1'b1;
				match_idx = lfu_pkg::IDX_W'(i);
			end
		end
	end

	// bump and move behind every later slot with count at most the new count
	always_comb begin
		uses_new = (ent_q[slot_q].uses == lfu_pkg::USES_MAX) ? ent_q[slot_q].uses
			: ent_q[slot_q].uses + 32'd1;
		moved = ent_q[slot_q];
		moved.uses = uses_new;
		if (put_q)
			moved.data = val_q;
		q_pos = lfu_pkg::CNT_W'(lfu_pkg::CAPACITY);
		for (int i = lfu_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (lfu_pkg::CNT_W'(i) > lfu_pkg::CNT_W'(slot_q)
					&& (lfu_pkg::CNT_W'(i) >= occ_q || ent_q[i].uses > uses_new))
				q_pos = lfu_pkg::CNT_W'(i);
		end
		for (int i = 0; i < lfu_pkg::CAPACITY; i++) begin
			bump_d[i] = ent_q[i];
			if (lfu_pkg::CNT_W'(i) + lfu_pkg::CNT_W'(1) == q_pos)
				bump_d[i] = moved;
			else if (lfu_pkg::CNT_W'(i) >= lfu_pkg::CNT_W'(slot_q)
					&& lfu_pkg::CNT_W'(i) + lfu_pkg::CNT_W'(1) < q_pos
					&& i + 1 < lfu_pkg::CAPACITY)
				bump_d[i] = ent_q[(i + 1) % lfu_pkg::CAPACITY];
		end
	end

	// drop the front entry
	always_comb begin
		for (int i = 0; i < lfu_pkg::CAPACITY; i++) begin
			if (i + 1 < lfu_pkg::CAPACITY)
				evict_d[i] = ent_q[(i + 1) % lfu_pkg::CAPACITY];
			else
				evict_d[i] = ent_q[i];
		end
	end

	// new key lands behind the leading run of zero counts
	always_comb begin
		fresh.key = key_q;
		fresh.data = val_q;
		fresh.uses = '0;
		z_pos = occ_q;
		for (int i = lfu_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (lfu_pkg::CNT_W'(i) >= occ_q || ent_q[i].uses != '0)
				z_pos = lfu_pkg::CNT_W'(i);
		end
		for (int i = 0; i < lfu_pkg::CAPACITY; i++) begin
			ins_d[i] = ent_q[i];
			if (lfu_pkg::CNT_W'(i) == z_pos)
				ins_d[i] = fresh;
			else if (lfu_pkg::CNT_W'(i) > z_pos && i > 0)
				ins_d[i] = ent_q[(i + lfu_pkg::CAPACITY - 1) % lfu_pkg::CAPACITY];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lfu_pkg::OP_BUMP:   ent_q <= bump_d;
			lfu_pkg::OP_EVICT:  ent_q <= evict_d;
			lfu_pkg::OP_INSERT: ent_q <= ins_d;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lfu_pkg::OP_LOAD: begin
				key_q <= req.lookup_key;
				val_q <= req.store_value;
				put_q <= (req.kind == lfu_pkg::KIND_PUT);
			end
			lfu_pkg::OP_FIND: begin
				found_q <= match_any;
				slot_q <= match_idx;
				hit_data_q <= ent_q[match_idx].data;
			end
			lfu_pkg::OP_RESULT: begin
				if (put_q) begin
					rsp_q.found <= found_q && !cap_zero;
					rsp_q.read_value <= '0;
				end else begin
					rsp_q.found <= found_q;
					rsp_q.read_value <= found_q ? hit_data_q : lfu_pkg::MISS_VALUE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cap_q <= lfu_pkg::CFG_RESET;
		end else begin
			if (cfg_we)
				cap_q <= cfg_data;
			if (cmd.op == lfu_pkg::OP_EVICT && occ_q != '0)
				occ_q <= occ_q - lfu_pkg::CNT_W'(1);
			else if (cmd.op == lfu_pkg::OP_INSERT)
				occ_q <= occ_q + lfu_pkg::CNT_W'(1);
		end
	end

	assign stat.found = found_q;
	assign stat.put = put_q;
	assign stat.cap_zero = cap_zero;
	assign stat.full = (lfu_pkg::CMP_W'(occ_q) >= eff_cap);
	assign rsp = rsp_q;
	assign occupancy = occ_q;

endmodule

// ===== sv/lfu_ctrl.sv =====
// sequencing state machine of the lfu cache table
module lfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  lfu_pkg::stat_t stat,
	output lfu_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_APPLY,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic rsp_valid_q;
	logic out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd.op = lfu_pkg::OP_NONE;
		unique case (state_q)
			ST_IDLE: if (req_valid) cmd.op = lfu_pkg::OP_LOAD;
			ST_FIND: cmd.op = lfu_pkg::OP_FIND;
			ST_APPLY: begin
				if (stat.found && !(stat.put && stat.cap_zero))
					cmd.op = lfu_pkg::OP_BUMP;
				else if (stat.put && !stat.cap_zero)
					cmd.op = stat.full ? lfu_pkg::OP_EVICT : lfu_pkg::OP_INSERT;
			end
			ST_RESULT: if (out_free) cmd.op = lfu_pkg::OP_RESULT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (req_valid) state_q <= ST_FIND;
				ST_FIND: state_q <= ST_APPLY;
				ST_APPLY: begin
					if (cmd.op != lfu_pkg::OP_EVICT)
						state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule
